/* hdl/ffsa_pkg.sv */
// Shared types, constants and command codes of the first-fit segment allocator.
`default_nettype none
package ffsa_pkg;

    localparam int unsigned MAX_FREE_DEF = 64;
    localparam int unsigned MAX_USED_DEF = 64;

    localparam logic [31:0] POOL_RESET  = 32'd67108864;
    localparam logic [4:0]  ALIGN_RESET = 5'd8;
    localparam logic [63:0] PHYS_RESET  = 64'h0000_0000_C400_0000;

    localparam logic [1:0] CFG_POOL  = 2'd0;
    localparam logic [1:0] CFG_ALIGN = 2'd1;
    localparam logic [1:0] CFG_PHYS  = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_UNK  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [4:0] CMD_NOP        = 5'd0;
    localparam logic [4:0] CMD_INIT       = 5'd1;
    localparam logic [4:0] CMD_LOAD       = 5'd2;
    localparam logic [4:0] CMD_SIZE       = 5'd3;
    localparam logic [4:0] CMD_FRD_IDX    = 5'd4;
    localparam logic [4:0] CMD_IDX_INC    = 5'd5;
    localparam logic [4:0] CMD_ALLOC_TAKE = 5'd6;
    localparam logic [4:0] CMD_FRD_M1     = 5'd7;
    localparam logic [4:0] CMD_FWR_M      = 5'd8;
    localparam logic [4:0] CMD_FC_DEC     = 5'd9;
    localparam logic [4:0] CMD_FAPPEND    = 5'd10;
    localparam logic [4:0] CMD_UAPPEND    = 5'd11;
    localparam logic [4:0] CMD_URD_UK     = 5'd12;
    localparam logic [4:0] CMD_UK_INC     = 5'd13;
    localparam logic [4:0] CMD_FREE_PUSH  = 5'd14;
    localparam logic [4:0] CMD_URD_M1     = 5'd15;
    localparam logic [4:0] CMD_UWR_M      = 5'd16;
    localparam logic [4:0] CMD_UC_DEC     = 5'd17;
    localparam logic [4:0] CMD_MRG_START  = 5'd18;
    localparam logic [4:0] CMD_MRG_LATI   = 5'd19;
    localparam logic [4:0] CMD_JDX_INC    = 5'd20;
    localparam logic [4:0] CMD_FRD_J      = 5'd21;
    localparam logic [4:0] CMD_MRG_JOIN   = 5'd22;
    localparam logic [4:0] CMD_RESULT     = 5'd23;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } t_seg;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] st;
        logic       cfg_we;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic uc_full;
        logic fc_full;
        logic size_ovf;
        logic idx_lt_fc;
        logic fit;
        logic fm1_lt_fc;
        logic rest_nz;
        logic uk_lt_uc;
        logic hit;
        logic um1_lt_uc;
        logic jdx_lt_fc;
        logic jdx_eq_idx;
        logic adj;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

/* hdl/first_fit_segment_allocator.sv */
// Top level of the first-fit segment allocator with free-list coalescing.
//
//   channel  handshake                  payload
//   cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//   in       i_in_valid / o_in_ready    i_opcode, i_request_bytes, i_release_offset
//   out      o_out_valid / i_out_ready  o_status, o_granted_offset/_phys/_bytes
//
// One request at a time; every segment table access goes through the single
// registered read port of each table. Allocate: scan the free list to the hit k,
// then move the entries behind it down on removal. Free: scan the used entries,
// then the pairwise merge, visiting entry pairs and restarting after each merge.
// After reset, S_INIT writes the whole-pool segment before the first beat is taken.
// A finished result waits in the output register; a new beat is taken meanwhile.
`default_nettype none
module first_fit_segment_allocator #(
    parameter int unsigned MAX_FREE_SEGMENTS = ffsa_pkg::MAX_FREE_DEF,
    parameter int unsigned MAX_USED_SEGMENTS = ffsa_pkg::MAX_USED_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_opcode,
    input  wire  [31:0] i_request_bytes,
    input  wire  [31:0] i_release_offset,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_granted_offset,
    output logic [63:0] o_granted_phys,
    output logic [31:0] o_granted_bytes
);
    import ffsa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ffsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready),
        .o_cfg_ready (o_cfg_ready)
    );

    ffsa_dpath #(
        .MAX_FREE (MAX_FREE_SEGMENTS),
        .MAX_USED (MAX_USED_SEGMENTS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_request_bytes  (i_request_bytes),
        .i_release_offset (i_release_offset),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_granted_offset (o_granted_offset),
        .o_granted_phys   (o_granted_phys),
        .o_granted_bytes  (o_granted_bytes)
    );

endmodule
`default_nettype wire

/* hdl/ffsa_ctrl.sv */
// Sequencer of the allocator: steps scans, shifts and merges through the datapath.
`default_nettype none
module ffsa_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_cfg_valid,
    input  ffsa_pkg::t_sts i_sts,
    output ffsa_pkg::t_cmd o_cmd,
    output logic           o_in_ready,
    output logic           o_cfg_ready
);
    import ffsa_pkg::*;

    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_A_RD  = 5'd3;
    localparam logic [4:0] S_A_CHK = 5'd4;
    localparam logic [4:0] S_SH_RD = 5'd5;
    localparam logic [4:0] S_SH_WR = 5'd6;
    localparam logic [4:0] S_A_RST = 5'd7;
    localparam logic [4:0] S_A_USE = 5'd8;
    localparam logic [4:0] S_U_RD  = 5'd9;
    localparam logic [4:0] S_U_CHK = 5'd10;
    localparam logic [4:0] S_UH_RD = 5'd11;
    localparam logic [4:0] S_UH_WR = 5'd12;
    localparam logic [4:0] S_M0    = 5'd13;
    localparam logic [4:0] S_MI    = 5'd14;
    localparam logic [4:0] S_MI_W  = 5'd15;
    localparam logic [4:0] S_MJ    = 5'd16;
    localparam logic [4:0] S_MJ_W  = 5'd17;
    localparam logic [4:0] S_RES   = 5'd18;

    logic [4:0] r_state, n_state;
    logic [1:0] r_st, n_st;
    logic [4:0] w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        w_op    = CMD_NOP;
        case (r_state)
            S_INIT: begin
                w_op    = CMD_INIT;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op    = CMD_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                w_op = CMD_SIZE;
                if (i_sts.op == OP_FREE) begin
                    n_state = S_U_RD;
                end else if (i_sts.uc_full) begin
                    n_st    = ST_FULL;
                    n_state = S_RES;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_A_RD: begin
                if (i_sts.size_ovf || !i_sts.idx_lt_fc) begin
                    n_st    = ST_OOM;
                    n_state = S_RES;
                end else begin
                    w_op    = CMD_FRD_IDX;
                    n_state = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (i_sts.fit) begin
                    w_op    = CMD_ALLOC_TAKE;
                    n_state = S_SH_RD;
                end else begin
                    w_op    = CMD_IDX_INC;
                    n_state = S_A_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.fm1_lt_fc) begin
                    w_op    = CMD_FRD_M1;
                    n_state = S_SH_WR;
                end else begin
                    w_op    = CMD_FC_DEC;
                    n_state = (i_sts.op == OP_FREE) ? S_M0 : S_A_RST;
                end
            end
            S_SH_WR: begin
                w_op    = CMD_FWR_M;
                n_state = S_SH_RD;
            end
            S_A_RST: begin
                if (i_sts.rest_nz) begin
                    w_op = CMD_FAPPEND;
                end
                n_state = S_A_USE;
            end
            S_A_USE: begin
                w_op    = CMD_UAPPEND;
                n_st    = ST_OK;
                n_state = S_RES;
            end
            S_U_RD: begin
                if (i_sts.uk_lt_uc) begin
                    w_op    = CMD_URD_UK;
                    n_state = S_U_CHK;
                end else begin
                    n_st    = ST_UNK;
                    n_state = S_RES;
                end
            end
            S_U_CHK: begin
                if (!i_sts.hit) begin
                    w_op    = CMD_UK_INC;
                    n_state = S_U_RD;
                end else if (i_sts.fc_full) begin
                    n_st    = ST_FULL;
                    n_state = S_RES;
                end else begin
                    w_op    = CMD_FREE_PUSH;
                    n_state = S_UH_RD;
                end
            end
            S_UH_RD: begin
                if (i_sts.um1_lt_uc) begin
                    w_op    = CMD_URD_M1;
                    n_state = S_UH_WR;
                end else begin
                    w_op    = CMD_UC_DEC;
                    n_state = S_M0;
                end
            end
            S_UH_WR: begin
                w_op    = CMD_UWR_M;
                n_state = S_UH_RD;
            end
            S_M0: begin
                w_op    = CMD_MRG_START;
                n_state = S_MI;
            end
            S_MI: begin
                if (i_sts.idx_lt_fc) begin
                    w_op    = CMD_FRD_IDX;
                    n_state = S_MI_W;
                end else begin
                    n_st    = ST_OK;
                    n_state = S_RES;
                end
            end
            S_MI_W: begin
                w_op    = CMD_MRG_LATI;
                n_state = S_MJ;
            end
            S_MJ: begin
                if (!i_sts.jdx_lt_fc) begin
                    w_op    = CMD_IDX_INC;
                    n_state = S_MI;
                end else if (i_sts.jdx_eq_idx) begin
                    w_op    = CMD_JDX_INC;
                end else begin
                    w_op    = CMD_FRD_J;
                    n_state = S_MJ_W;
                end
            end
            S_MJ_W: begin
                if (i_sts.adj) begin
                    w_op    = CMD_MRG_JOIN;
                    n_state = S_SH_RD;
                end else begin
                    w_op    = CMD_JDX_INC;
                    n_state = S_MJ;
                end
            end
            S_RES: begin
                if (!i_sts.out_busy) begin
                    w_op    = CMD_RESULT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        o_cmd.op     = w_op;
        o_cmd.st     = r_st;
        o_cmd.cfg_we = i_cfg_valid && (r_state == S_IDLE);
    end

endmodule
`default_nettype wire

/* hdl/ffsa_dpath.sv */
// Datapath of the allocator: segment memories, counters, config and result registers.
`default_nettype none
module ffsa_dpath #(
    parameter int unsigned MAX_FREE = ffsa_pkg::MAX_FREE_DEF,
    parameter int unsigned MAX_USED = ffsa_pkg::MAX_USED_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  ffsa_pkg::t_cmd  i_cmd,
    output ffsa_pkg::t_sts  o_sts,
    input  wire      [1:0]  i_cfg_index,
    input  wire      [63:0] i_cfg_data,
    input  wire             i_opcode,
    input  wire      [31:0] i_request_bytes,
    input  wire      [31:0] i_release_offset,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output logic     [1:0]  o_status,
    output logic     [31:0] o_granted_offset,
    output logic     [63:0] o_granted_phys,
    output logic     [31:0] o_granted_bytes
);
    import ffsa_pkg::*;

    localparam int FC_W = $clog2(MAX_FREE + 1);
    localparam int FI_W = $clog2(MAX_FREE);
    localparam int UC_W = $clog2(MAX_USED + 1);
    localparam int UI_W = $clog2(MAX_USED);
    localparam logic [FC_W-1:0] F_ONE = FC_W'(1);
    localparam logic [UC_W-1:0] U_ONE = UC_W'(1);
    localparam logic [FC_W-1:0] F_MAX = FC_W'(MAX_FREE);
    localparam logic [UC_W-1:0] U_MAX = UC_W'(MAX_USED);

    t_seg r_fmem [MAX_FREE];
    t_seg r_umem [MAX_USED];
    t_seg r_frd, r_urd;

    logic [31:0] r_pool;
    logic [4:0]  r_align;
    logic [63:0] r_base;
    logic [FC_W-1:0] r_fc, r_idx, r_jdx, r_fm;
    logic [UC_W-1:0] r_uc, r_uk, r_um;
    logic        r_op;
    logic [31:0] r_req, r_rel;
    logic [32:0] r_size;
    logic [31:0] r_off, r_len, r_si, r_li;

    logic        r_ovalid;
    logic [1:0]  r_status;
    logic [31:0] r_goff, r_gbytes;
    logic [63:0] r_gphys;

    logic            f_we, f_re, u_we, u_re;
    logic [FI_W-1:0] f_wa, f_ra;
    logic [UI_W-1:0] u_wa, u_ra;
    t_seg            f_wd, u_wd;
    logic [32:0]     w_am1, w_end, w_sum;
    logic [FC_W-1:0] w_fm1;
    logic [UC_W-1:0] w_um1;
    logic            w_pool_we;

    assign w_am1     = (33'd1 << r_align) - 33'd1;
    assign w_end     = {1'b0, r_si} + {1'b0, r_li};
    assign w_sum     = {1'b0, r_li} + {1'b0, r_frd.len};
    assign w_fm1     = r_fm + F_ONE;
    assign w_um1     = r_um + U_ONE;
    assign w_pool_we = i_cmd.cfg_we && (i_cfg_index == CFG_POOL);

    always_comb begin
        f_we = 1'b0;
        f_wa = '0;
        f_wd = '0;
        f_re = 1'b0;
        f_ra = '0;
        u_we = 1'b0;
        u_wa = '0;
        u_wd = '0;
        u_re = 1'b0;
        u_ra = '0;
        case (i_cmd.op)
            CMD_INIT: begin
                f_we = 1'b1;
                f_wd = '{start: 32'd0, len: r_pool};
            end
            CMD_FRD_IDX: begin
                f_re = 1'b1;
                f_ra = r_idx[FI_W-1:0];
            end
            CMD_FRD_J: begin
                f_re = 1'b1;
                f_ra = r_jdx[FI_W-1:0];
            end
            CMD_FRD_M1: begin
                f_re = 1'b1;
                f_ra = w_fm1[FI_W-1:0];
            end
            CMD_FWR_M: begin
                f_we = 1'b1;
                f_wa = r_fm[FI_W-1:0];
                f_wd = r_frd;
            end
            CMD_FAPPEND: begin
                f_we = 1'b1;
                f_wa = r_fc[FI_W-1:0];
                f_wd = '{start: r_off + r_size[31:0], len: r_len - r_size[31:0]};
            end
            CMD_FREE_PUSH: begin
                f_we = 1'b1;
                f_wa = r_fc[FI_W-1:0];
                f_wd = '{start: r_rel, len: r_urd.len};
            end
            CMD_MRG_JOIN: begin
                f_we = 1'b1;
                f_wa = r_idx[FI_W-1:0];
                f_wd = '{start: r_si, len: w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0]};
            end
            CMD_UAPPEND: begin
                u_we = 1'b1;
                u_wa = r_uc[UI_W-1:0];
                u_wd = '{start: r_off, len: r_size[31:0]};
            end
            CMD_URD_UK: begin
                u_re = 1'b1;
                u_ra = r_uk[UI_W-1:0];
            end
            CMD_URD_M1: begin
                u_re = 1'b1;
                u_ra = w_um1[UI_W-1:0];
            end
            CMD_UWR_M: begin
                u_we = 1'b1;
                u_wa = r_um[UI_W-1:0];
                u_wd = r_urd;
            end
            default: begin
            end
        endcase
        if (w_pool_we) begin
            f_we = 1'b1;
            f_wa = '0;
            f_wd = '{start: 32'd0, len: i_cfg_data[31:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_fmem[f_wa] <= f_wd;
        end
        if (f_re) begin
            r_frd <= r_fmem[f_ra];
        end
        if (u_we) begin
            r_umem[u_wa] <= u_wd;
        end
        if (u_re) begin
            r_urd <= r_umem[u_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_LOAD: begin
                r_req <= i_request_bytes;
                r_rel <= i_release_offset;
            end
            CMD_SIZE: begin
                r_size <= ({1'b0, r_req} + w_am1) & ~w_am1;
            end
            CMD_ALLOC_TAKE: begin
                r_off <= r_frd.start;
                r_len <= r_frd.len;
                r_fm  <= r_idx;
            end
            CMD_FREE_PUSH: begin
                r_len <= r_urd.len;
                r_um  <= r_uk;
            end
            CMD_FWR_M: begin
                r_fm <= w_fm1;
            end
            CMD_UWR_M: begin
                r_um <= w_um1;
            end
            CMD_MRG_LATI: begin
                r_si <= r_frd.start;
                r_li <= r_frd.len;
            end
            CMD_MRG_JOIN: begin
                r_fm <= r_jdx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool   <= POOL_RESET;
            r_align  <= ALIGN_RESET;
            r_base   <= PHYS_RESET;
            r_fc     <= (POOL_RESET != 32'd0) ? F_ONE : '0;
            r_uc     <= '0;
            r_idx    <= '0;
            r_jdx    <= '0;
            r_uk     <= '0;
            r_op     <= OP_ALLOC;
            r_ovalid <= 1'b0;
            r_status <= ST_OK;
            r_goff   <= '0;
            r_gphys  <= '0;
            r_gbytes <= '0;
        end else begin
            if (i_cmd.cfg_we) begin
                case (i_cfg_index)
                    CFG_POOL: begin
                        r_pool <= i_cfg_data[31:0];
                        r_fc   <= (i_cfg_data[31:0] != 32'd0) ? F_ONE : '0;
                    end
                    CFG_ALIGN: r_align <= i_cfg_data[4:0];
                    CFG_PHYS:  r_base  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                CMD_LOAD:      r_op  <= i_opcode;
                CMD_SIZE: begin
                    r_idx <= '0;
                    r_uk  <= '0;
                end
                CMD_IDX_INC:   r_idx <= r_idx + F_ONE;
                CMD_JDX_INC:   r_jdx <= r_jdx + F_ONE;
                CMD_UK_INC:    r_uk  <= r_uk + U_ONE;
                CMD_FC_DEC:    r_fc  <= r_fc - F_ONE;
                CMD_FAPPEND:   r_fc  <= r_fc + F_ONE;
                CMD_FREE_PUSH: r_fc  <= r_fc + F_ONE;
                CMD_UAPPEND:   r_uc  <= r_uc + U_ONE;
                CMD_UC_DEC:    r_uc  <= r_uc - U_ONE;
                CMD_MRG_START: r_idx <= '0;
                CMD_MRG_LATI:  r_jdx <= '0;
                CMD_RESULT: begin
                    r_ovalid <= 1'b1;
                    r_status <= i_cmd.st;
                    r_goff   <= '0;
                    r_gphys  <= '0;
                    r_gbytes <= '0;
                    if (i_cmd.st == ST_OK) begin
                        if (r_op == OP_ALLOC) begin
                            r_goff   <= r_off;
                            r_gphys  <= r_base + {32'd0, r_off};
                            r_gbytes <= r_size[31:0];
                        end else begin
                            r_gbytes <= r_len;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_sts.op         = r_op;
        o_sts.uc_full    = (r_uc >= U_MAX);
        o_sts.fc_full    = (r_fc >= F_MAX);
        o_sts.size_ovf   = r_size[32];
        o_sts.idx_lt_fc  = (r_idx < r_fc);
        o_sts.fit        = ({1'b0, r_frd.len} >= r_size);
        o_sts.fm1_lt_fc  = (w_fm1 < r_fc);
        o_sts.rest_nz    = (r_len != r_size[31:0]);
        o_sts.uk_lt_uc   = (r_uk < r_uc);
        o_sts.hit        = (r_urd.start == r_rel);
        o_sts.um1_lt_uc  = (w_um1 < r_uc);
        o_sts.jdx_lt_fc  = (r_jdx < r_fc);
        o_sts.jdx_eq_idx = (r_jdx == r_idx);
        o_sts.adj        = (w_end == {1'b0, r_frd.start});
        o_sts.out_busy   = r_ovalid;
    end

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_status;
    assign o_granted_offset = r_goff;
    assign o_granted_phys   = r_gphys;
    assign o_granted_bytes  = r_gbytes;

endmodule
`default_nettype wire
